// ----- design/htfr_pkg.sv -----
// Shared constants and types for the header/tail frame receiver.
package htfr_pkg;

  localparam int FRAME_LENGTH = 11;

  localparam logic [7:0] HDR_FIRST      = 8'h55;
  localparam logic [7:0] HDR_SECOND     = 8'hAA;
  localparam logic [7:0] TAIL_MARK      = 8'h6B;
  localparam logic [7:0] WARN_INFRARED  = 8'hAA;
  localparam logic [7:0] WARN_TILT      = 8'hBB;
  localparam logic [7:0] POWER_AT_RESET = 8'd100;

  // Byte positions inside a frame.
  localparam int WARN_IDX      = 3;
  localparam int POWER_IDX     = 5;
  localparam int PAYLOAD_FIRST = 2;
  localparam int PAYLOAD_LAST  = 9;
  localparam int PAYLOAD_W     = (PAYLOAD_LAST - PAYLOAD_FIRST + 1) * 8;

  typedef struct packed {
    logic                 frame_accepted;
    logic                 has_valid_frame;
    logic [7:0]           warning_code;
    logic                 infrared_warning;
    logic                 tilt_warning;
    logic [7:0]           power_percent;
    logic [PAYLOAD_W-1:0] latest_payload;
  } result_t;

endpackage

// ----- design/htfr_if.sv -----
// Valid/ready channel interfaces for received bytes and status results.
interface htfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface htfr_out_if;
  logic                           valid;
  logic                           ready;
  logic                           frame_accepted;
  logic                           has_valid_frame;
  logic [7:0]                     warning_code;
  logic                           infrared_warning;
  logic                           tilt_warning;
  logic [7:0]                     power_percent;
  logic [htfr_pkg::PAYLOAD_W-1:0] latest_payload;

  modport source (output valid, output frame_accepted, output has_valid_frame,
                  output warning_code, output infrared_warning, output tilt_warning,
                  output power_percent, output latest_payload, input ready);
  modport sink   (input valid, input frame_accepted, input has_valid_frame,
                  input warning_code, input infrared_warning, input tilt_warning,
                  input power_percent, input latest_payload, output ready);
endinterface

// ----- design/htfr_parser.sv -----
// Header sync, frame collection, tail check and latched frame state.
module htfr_parser #(
  parameter int FRAME_LENGTH = htfr_pkg::FRAME_LENGTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  output htfr_pkg::result_t result
);

  localparam int POS_W = $clog2(FRAME_LENGTH);
  localparam logic [POS_W-1:0] POS_IDLE = POS_W'(0);
  localparam logic [POS_W-1:0] POS_HDR2 = POS_W'(1);
  localparam logic [POS_W-1:0] POS_BODY = POS_W'(2);
  localparam logic [POS_W-1:0] POS_TAIL = POS_W'(FRAME_LENGTH - 1);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             accept;

  logic [7:0] rx_bytes_r [htfr_pkg::PAYLOAD_FIRST:FRAME_LENGTH-2];
  logic [7:0] latest_r   [htfr_pkg::PAYLOAD_FIRST:htfr_pkg::PAYLOAD_LAST];
  logic [7:0] latest_nxt [htfr_pkg::PAYLOAD_FIRST:htfr_pkg::PAYLOAD_LAST];
  logic [7:0] power_r, power_nxt;
  logic [7:0] warning_r, warning_nxt;
  logic       valid_seen_r, valid_seen_nxt;

  always_comb begin
    pos_nxt = pos_r;
    accept  = 1'b0;
    if (pos_r == POS_IDLE) begin
      pos_nxt = (rx_byte == htfr_pkg::HDR_FIRST) ? POS_HDR2 : POS_IDLE;
    end else if (pos_r == POS_HDR2) begin
      // a repeated first header byte restarts the header
      if (rx_byte == htfr_pkg::HDR_SECOND) begin
        pos_nxt = POS_BODY;
      end else if (rx_byte == htfr_pkg::HDR_FIRST) begin
        pos_nxt = POS_HDR2;
      end else begin
        pos_nxt = POS_IDLE;
      end
    end else if (pos_r == POS_TAIL) begin
      pos_nxt = POS_IDLE;
      accept  = (rx_byte == htfr_pkg::TAIL_MARK);
    end else begin
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_IDLE;
    end else if (step) begin
      pos_r <= pos_nxt;
    end
  end

  // Body bytes; the tail byte is checked on arrival and never held here.
  for (genvar i = htfr_pkg::PAYLOAD_FIRST; i <= FRAME_LENGTH - 2; i++) begin : g_rx
    always_ff @(posedge clk) begin
      if (step && pos_r == POS_W'(i)) begin
        rx_bytes_r[i] <= rx_byte;
      end
    end
  end

  for (genvar i = htfr_pkg::PAYLOAD_FIRST; i <= htfr_pkg::PAYLOAD_LAST; i++) begin : g_latest
    if (i < FRAME_LENGTH - 1) begin : g_body
      assign latest_nxt[i] = accept ? rx_bytes_r[i] : latest_r[i];
    end else if (i == FRAME_LENGTH - 1) begin : g_tail
      assign latest_nxt[i] = accept ? htfr_pkg::TAIL_MARK : latest_r[i];
    end else begin : g_beyond
      assign latest_nxt[i] = 8'd0;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        latest_r[i] <= 8'd0;
      end else if (step) begin
        latest_r[i] <= latest_nxt[i];
      end
    end
  end

  assign power_nxt      = accept ? rx_bytes_r[htfr_pkg::POWER_IDX] : power_r;
  assign warning_nxt    = accept ? rx_bytes_r[htfr_pkg::WARN_IDX] : warning_r;
  assign valid_seen_nxt = valid_seen_r | accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_r      <= htfr_pkg::POWER_AT_RESET;
      warning_r    <= 8'd0;
      valid_seen_r <= 1'b0;
    end else if (step) begin
      power_r      <= power_nxt;
      warning_r    <= warning_nxt;
      valid_seen_r <= valid_seen_nxt;
    end
  end

  // Status shows the state after this byte.
  always_comb begin
    result.frame_accepted   = accept;
    result.has_valid_frame  = valid_seen_nxt;
    result.warning_code     = warning_nxt;
    result.infrared_warning = (warning_nxt == htfr_pkg::WARN_INFRARED);
    result.tilt_warning     = (warning_nxt == htfr_pkg::WARN_TILT);
    result.power_percent    = power_nxt;
    for (int i = htfr_pkg::PAYLOAD_FIRST; i <= htfr_pkg::PAYLOAD_LAST; i++) begin
      result.latest_payload[(i - htfr_pkg::PAYLOAD_FIRST) * 8 +: 8] = latest_nxt[i];
    end
  end

  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_TAIL)
    else $error("frame position past the tail slot");

  a_accept_at_tail: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (pos_r == POS_TAIL && rx_byte == htfr_pkg::TAIL_MARK))
    else $error("frame accepted away from the tail slot");

  a_accept_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (step && accept) |=> (pos_r == POS_IDLE && valid_seen_r))
    else $error("accepted frame did not restart search and set valid mark");

  a_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    valid_seen_r |=> valid_seen_r)
    else $error("valid mark dropped without reset");

endmodule

// ----- design/header_tail_frame_receiver.sv -----
// Top level: byte input register, frame parser and registered status output.
//
//   channel  | dir | handshake          | payload
//   in_chan  | in  | valid/ready        | rx_byte[7:0]
//   out_chan | out | valid/ready        | status of the frame receiver, one per byte
//
// One byte enters per cycle unless a waiting result stalls the input; each byte's status
// passes the input register, the parser and then the result register before it is valid.
// Both stages stall together while a result waits; a byte is still taken when the
// input register is empty. Reset (rst_n low, synchronous) empties both stages and
// clears the position, the latched frame, the valid mark and sets power to 100.
module header_tail_frame_receiver #(
  parameter int FRAME_LENGTH = htfr_pkg::FRAME_LENGTH
) (
  input logic        clk,
  input logic        rst_n,
  htfr_in_if.sink    in_chan,
  htfr_out_if.source out_chan
);

  logic              s1_valid_r;
  logic [7:0]        s1_byte_r;
  logic              out_valid_r;
  htfr_pkg::result_t out_res_r;
  htfr_pkg::result_t result;
  logic              advance;
  logic              step;

  assign advance       = !out_valid_r || out_chan.ready;
  assign step          = advance && s1_valid_r;
  assign in_chan.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_chan.ready) begin
        s1_valid_r <= in_chan.valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_byte_r <= in_chan.rx_byte;
    end
    if (step) begin
      out_res_r <= result;
    end
  end

  htfr_parser #(
    .FRAME_LENGTH(FRAME_LENGTH)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .rx_byte(s1_byte_r),
    .result (result)
  );

  assign out_chan.valid            = out_valid_r;
  assign out_chan.frame_accepted   = out_res_r.frame_accepted;
  assign out_chan.has_valid_frame  = out_res_r.has_valid_frame;
  assign out_chan.warning_code     = out_res_r.warning_code;
  assign out_chan.infrared_warning = out_res_r.infrared_warning;
  assign out_chan.tilt_warning     = out_res_r.tilt_warning;
  assign out_chan.power_percent    = out_res_r.power_percent;
  assign out_chan.latest_payload   = out_res_r.latest_payload;

endmodule
